// ===== rtl/cpsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsc_pkg
// Shared types, codes and helpers of the carriage position seek controller.
// ----------------------------------------------------------------------------
package cpsc_pkg;

    localparam int DATA_W      = 32;
    localparam int THR_W       = 16;
    localparam int CMD_W       = 3;
    localparam int MODE_W      = 4;
    localparam int DUTY_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    // command codes as they arrive on the cmd field
    typedef enum logic [CMD_W-1:0] {
        OP_READY    = 3'd0,
        OP_SCAN     = 3'd1,
        OP_EJECT    = 3'd2,
        OP_TRANSFER = 3'd3,
        OP_HALT     = 3'd4,
        OP_INIT     = 3'd5,
        OP_TICK     = 3'd6,
        OP_REACHED  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        DRV_OFF = 2'd0,
        DRV_FWD = 2'd1,
        DRV_REV = 2'd2
    } drive_t;

    localparam logic [DUTY_W-1:0] DUTY_OFF = 8'h00;
    localparam logic [DUTY_W-1:0] DUTY_FWD = 8'hAA;
    localparam logic [DUTY_W-1:0] DUTY_REV = 8'h99;

    // external mode codes
    localparam logic [MODE_W-1:0] MODE_INIT          = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SEEK_READY    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_AT_READY      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SEEK_SCAN     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_AT_SCAN       = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SEEK_EJECT    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_AT_EJECT      = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SEEK_TRANSFER = 4'd7;
    localparam logic [MODE_W-1:0] MODE_AT_TRANSFER   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_STALLED       = 4'd9;
    localparam logic [MODE_W-1:0] MODE_UNDEFINED     = 4'd10;

    // internal one-hot mode state
    typedef enum logic [10:0] {
        ST_INIT          = 11'b000_0000_0001,
        ST_SEEK_READY    = 11'b000_0000_0010,
        ST_AT_READY      = 11'b000_0000_0100,
        ST_SEEK_SCAN     = 11'b000_0000_1000,
        ST_AT_SCAN       = 11'b000_0001_0000,
        ST_SEEK_EJECT    = 11'b000_0010_0000,
        ST_AT_EJECT      = 11'b000_0100_0000,
        ST_SEEK_TRANSFER = 11'b000_1000_0000,
        ST_AT_TRANSFER   = 11'b001_0000_0000,
        ST_STALLED       = 11'b010_0000_0000,
        ST_UNDEFINED     = 11'b100_0000_0000
    } mode_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READY_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_TARGET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EJECT_TARGET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_TARGET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_THRESHOLD = 3'd6;

    typedef struct packed {
        logic [DATA_W-1:0] ready_target;
        logic [DATA_W-1:0] scan_target;
        logic [DATA_W-1:0] eject_target;
        logic [DATA_W-1:0] transfer_target;
        logic [DATA_W-1:0] home_target;
        logic [THR_W-1:0]  backlash_offset;
        logic [THR_W-1:0]  stall_threshold;
    } cfg_t;

    // classified beat handed from front to back
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] pos;
        logic              seek_rev;
        logic [DATA_W-1:0] seek_cmp;
    } entry_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        drive_t            drive;
        logic [DUTY_W-1:0] duty;
        logic [DATA_W-1:0] compare_position;
        logic              compare_less_equal;
        logic              lamp_on;
        logic              stall_flag;
        logic              clear_position;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] c;
        case (m)
            ST_INIT:          c = MODE_INIT;
            ST_SEEK_READY:    c = MODE_SEEK_READY;
            ST_AT_READY:      c = MODE_AT_READY;
            ST_SEEK_SCAN:     c = MODE_SEEK_SCAN;
            ST_AT_SCAN:       c = MODE_AT_SCAN;
            ST_SEEK_EJECT:    c = MODE_SEEK_EJECT;
            ST_AT_EJECT:      c = MODE_AT_EJECT;
            ST_SEEK_TRANSFER: c = MODE_SEEK_TRANSFER;
            ST_AT_TRANSFER:   c = MODE_AT_TRANSFER;
            ST_STALLED:       c = MODE_STALLED;
            default:          c = MODE_UNDEFINED;
        endcase
        return c;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(input drive_t d);
        logic [DUTY_W-1:0] v;
        case (d)
            DRV_FWD: v = DUTY_FWD;
            DRV_REV: v = DUTY_REV;
            default: v = DUTY_OFF;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cpsc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsc_front
// Accepts command beats, picks the station target and works out direction
// and armed compare value ahead of the state update.
// ----------------------------------------------------------------------------
module cpsc_front (
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cpsc_pkg::CMD_W-1:0]    cmd,
    input  wire logic [cpsc_pkg::DATA_W-1:0]   encoder_position,
    input  wire cpsc_pkg::cfg_t                cfg,
    input  wire logic                          q_full,
    output logic                               q_push,
    output cpsc_pkg::entry_t                   q_data
);

    cpsc_pkg::op_t                 op;
    logic [cpsc_pkg::DATA_W-1:0]   target;
    logic [cpsc_pkg::DATA_W-1:0]   ref_pos;
    logic [cpsc_pkg::DATA_W-1:0]   bl_ext;
    logic                          rev;

    assign op       = cpsc_pkg::op_t'(cmd);
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // a tick only ever seeks eject, and then from the freshly zeroed counter
    always_comb
    begin
        ref_pos = encoder_position;
        case (op)
            cpsc_pkg::OP_READY:    target = cfg.ready_target;
            cpsc_pkg::OP_SCAN:     target = cfg.scan_target;
            cpsc_pkg::OP_TRANSFER: target = cfg.transfer_target;
            cpsc_pkg::OP_INIT:     target = cfg.home_target;
            cpsc_pkg::OP_TICK:
            begin
                target  = cfg.eject_target;
                ref_pos = '0;
            end
            default:               target = cfg.eject_target;
        endcase
    end

    assign bl_ext = {{(cpsc_pkg::DATA_W-cpsc_pkg::THR_W){1'b0}}, cfg.backlash_offset};
    assign rev    = $signed(target) < $signed(ref_pos);

    assign q_data.op       = op;
    assign q_data.pos      = encoder_position;
    assign q_data.seek_rev = rev;
    assign q_data.seek_cmp = rev ? (target + bl_ext) : (target - bl_ext);

endmodule
`default_nettype wire

// ===== rtl/cpsc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsc_queue
// Short register FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module cpsc_queue #(
    parameter int DEPTH = cpsc_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cpsc_pkg::entry_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output cpsc_pkg::entry_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cpsc_pkg::entry_t  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full     = (count_reg == FULL_CNT);
    assign valid    = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cpsc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsc_back
// Mode state machine, drive, compare, lamp and stall tracking. The state
// registers double as the result register.
// ----------------------------------------------------------------------------
module cpsc_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire cpsc_pkg::entry_t             q_data,
    output logic                              q_pop,
    input  wire logic [cpsc_pkg::THR_W-1:0]   stall_threshold,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output cpsc_pkg::result_t                 res
);

    localparam int DIST_W = cpsc_pkg::DATA_W + 2;

    cpsc_pkg::mode_t              mode_reg,     mode_next;
    cpsc_pkg::drive_t             drive_reg,    drive_next;
    logic [cpsc_pkg::DATA_W-1:0]  cmp_reg,      cmp_next;
    logic                         dir_reg,      dir_next;
    logic                         lamp_reg,     lamp_next;
    logic                         stall_reg,    stall_next;
    logic                         was_mov_reg,  was_mov_next;
    logic [cpsc_pkg::DATA_W-1:0]  last_pos_reg, last_pos_next;
    logic                         clear_reg,    clear_next;
    logic                         out_valid_reg;

    logic                         pop;
    logic                         moving;
    logic                         do_seek;
    logic [DIST_W-1:0]            delta;
    logic [DIST_W-1:0]            thr_ext;
    logic                         small_move;

    assign pop   = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = pop;

    assign moving = (mode_reg == cpsc_pkg::ST_SEEK_READY)
                 || (mode_reg == cpsc_pkg::ST_SEEK_SCAN)
                 || (mode_reg == cpsc_pkg::ST_SEEK_EJECT)
                 || (mode_reg == cpsc_pkg::ST_SEEK_TRANSFER)
                 || (mode_reg == cpsc_pkg::ST_INIT);

    // exact signed movement since the previous tick, checked against +/- thr
    assign delta      = {{2{q_data.pos[cpsc_pkg::DATA_W-1]}}, q_data.pos}
                      - {{2{last_pos_reg[cpsc_pkg::DATA_W-1]}}, last_pos_reg};
    assign thr_ext    = {{(DIST_W-cpsc_pkg::THR_W){1'b0}}, stall_threshold};
    assign small_move = ($signed(delta) <= $signed(thr_ext))
                     && ($signed(delta) >= -$signed(thr_ext));

    always_comb
    begin
        mode_next     = mode_reg;
        drive_next    = drive_reg;
        cmp_next      = cmp_reg;
        dir_next      = dir_reg;
        lamp_next     = lamp_reg;
        stall_next    = stall_reg;
        was_mov_next  = was_mov_reg;
        last_pos_next = last_pos_reg;
        clear_next    = 1'b0;
        do_seek       = 1'b0;
        case (q_data.op)
            cpsc_pkg::OP_READY:
            begin
                mode_next = cpsc_pkg::ST_SEEK_READY;
                lamp_next = 1'b0;
                do_seek   = 1'b1;
            end
            cpsc_pkg::OP_SCAN:
            begin
                mode_next = cpsc_pkg::ST_SEEK_SCAN;
                do_seek   = 1'b1;
            end
            cpsc_pkg::OP_EJECT:
            begin
                mode_next = cpsc_pkg::ST_SEEK_EJECT;
                lamp_next = 1'b0;
                do_seek   = 1'b1;
            end
            cpsc_pkg::OP_TRANSFER:
            begin
                mode_next = cpsc_pkg::ST_SEEK_TRANSFER;
                lamp_next = 1'b0;
                do_seek   = 1'b1;
            end
            cpsc_pkg::OP_HALT:
            begin
                drive_next = cpsc_pkg::DRV_OFF;
                lamp_next  = 1'b0;
            end
            cpsc_pkg::OP_INIT:
            begin
                mode_next = cpsc_pkg::ST_INIT;
                lamp_next = 1'b0;
                do_seek   = 1'b1;
            end
            cpsc_pkg::OP_TICK:
            begin
                if (moving && was_mov_reg)
                begin
                    if (small_move)
                    begin
                        stall_next = 1'b1;
                        drive_next = cpsc_pkg::DRV_OFF;
                        if (mode_reg == cpsc_pkg::ST_INIT)
                        begin
                            // homed against the stop: zero counter, go to eject
                            clear_next = 1'b1;
                            mode_next  = cpsc_pkg::ST_SEEK_EJECT;
                            do_seek    = 1'b1;
                        end
                        else
                        begin
                            mode_next = cpsc_pkg::ST_STALLED;
                        end
                    end
                    else
                    begin
                        stall_next = 1'b0;
                    end
                end
                last_pos_next = q_data.pos;
                was_mov_next  = moving;
            end
            cpsc_pkg::OP_REACHED:
            begin
                case (mode_reg)
                    cpsc_pkg::ST_SEEK_READY:    mode_next = cpsc_pkg::ST_AT_READY;
                    cpsc_pkg::ST_SEEK_EJECT:    mode_next = cpsc_pkg::ST_AT_EJECT;
                    cpsc_pkg::ST_SEEK_TRANSFER: mode_next = cpsc_pkg::ST_AT_TRANSFER;
                    cpsc_pkg::ST_SEEK_SCAN:
                    begin
                        mode_next = cpsc_pkg::ST_AT_SCAN;
                        lamp_next = 1'b1;
                    end
                    cpsc_pkg::ST_INIT:          mode_next = mode_reg;
                    cpsc_pkg::ST_STALLED:       drive_next = cpsc_pkg::DRV_OFF;
                    default:                    mode_next = cpsc_pkg::ST_UNDEFINED;
                endcase
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
        if (do_seek)
        begin
            drive_next = q_data.seek_rev ? cpsc_pkg::DRV_REV : cpsc_pkg::DRV_FWD;
            cmp_next   = q_data.seek_cmp;
            dir_next   = q_data.seek_rev;
            stall_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= cpsc_pkg::ST_INIT;
            drive_reg     <= cpsc_pkg::DRV_OFF;
            cmp_reg       <= '0;
            dir_reg       <= 1'b0;
            lamp_reg      <= 1'b0;
            stall_reg     <= 1'b0;
            was_mov_reg   <= 1'b0;
            last_pos_reg  <= '0;
            clear_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg     <= mode_next;
                drive_reg    <= drive_next;
                cmp_reg      <= cmp_next;
                dir_reg      <= dir_next;
                lamp_reg     <= lamp_next;
                stall_reg    <= stall_next;
                was_mov_reg  <= was_mov_next;
                last_pos_reg <= last_pos_next;
                clear_reg    <= clear_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid              = out_valid_reg;
    assign res.mode               = cpsc_pkg::mode_code(mode_reg);
    assign res.drive              = drive_reg;
    assign res.duty               = cpsc_pkg::duty_of(drive_reg);
    assign res.compare_position   = cmp_reg;
    assign res.compare_less_equal = dir_reg;
    assign res.lamp_on            = lamp_reg;
    assign res.stall_flag         = stall_reg;
    assign res.clear_position     = clear_reg;

    // halt always leaves the motor braked and the lamp off
    a_halt_brakes: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (q_data.op == cpsc_pkg::OP_HALT)
        |=> (drive_reg == cpsc_pkg::DRV_OFF) && !lamp_reg)
        else $error("halt did not brake");

    // a homing strobe comes only with the follow-up eject seek
    a_home_seek: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clear_reg
        |-> (mode_reg == cpsc_pkg::ST_SEEK_EJECT) && !stall_reg
            && (drive_reg != cpsc_pkg::DRV_OFF))
        else $error("home strobe without eject seek");

    // every move drives the motor and clears the stall flag
    a_move_drives: assert property (@(posedge clk) disable iff (!rst_n)
        pop && ((q_data.op == cpsc_pkg::OP_READY) || (q_data.op == cpsc_pkg::OP_SCAN)
            || (q_data.op == cpsc_pkg::OP_EJECT) || (q_data.op == cpsc_pkg::OP_TRANSFER)
            || (q_data.op == cpsc_pkg::OP_INIT))
        |=> !stall_reg && (drive_reg != cpsc_pkg::DRV_OFF)
            && (dir_reg == (drive_reg == cpsc_pkg::DRV_REV)))
        else $error("move did not arm drive");

endmodule
`default_nettype wire

// ===== rtl/carriage_position_seek_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// carriage_position_seek_controller_core
// Positioning controller for a motor-driven carriage: seek, stall and home.
// ----------------------------------------------------------------------------
// Takes one command beat per clock while in_ready is high and returns
// exactly one result beat per command, in order. A beat is classified in
// the front half (station target select, forward/reverse decision, compare
// value with backlash) in the cycle it is accepted and is registered in a
// short FIFO; the back half then pops it and applies it to the mode state
// registers, and a steady stream runs at one beat per cycle while out_ready
// stays high. The back state
// registers are the result register: they only update when the result slot
// is free or being taken, so a stalled output backs up into the FIFO and
// in_ready drops only when the FIFO is full. Configuration writes take effect
// on the next edge and must only be issued while no command is in flight.
// After reset the block reports the initializing mode with the motor braked.
// ----------------------------------------------------------------------------
module carriage_position_seek_controller_core #(
    parameter int QUEUE_DEPTH = cpsc_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_write,
    input  wire logic [cpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cpsc_pkg::DATA_W-1:0]       cfg_data,
    // command channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [cpsc_pkg::CMD_W-1:0]        cmd,
    input  wire logic [cpsc_pkg::DATA_W-1:0]       encoder_position,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [cpsc_pkg::MODE_W-1:0]            mode,
    output logic [1:0]                             drive,
    output logic [cpsc_pkg::DUTY_W-1:0]            duty,
    output logic [cpsc_pkg::DATA_W-1:0]            compare_position,
    output logic                                   compare_less_equal,
    output logic                                   lamp_on,
    output logic                                   stall_flag,
    output logic                                   clear_position
);

    cpsc_pkg::cfg_t     cfg_reg;
    cpsc_pkg::entry_t   push_data;
    cpsc_pkg::entry_t   pop_data;
    cpsc_pkg::result_t  res;
    logic               q_full;
    logic               q_push;
    logic               q_valid;
    logic               q_pop;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cpsc_pkg::CFG_READY_TARGET:    cfg_reg.ready_target    <= cfg_data;
                cpsc_pkg::CFG_SCAN_TARGET:     cfg_reg.scan_target     <= cfg_data;
                cpsc_pkg::CFG_EJECT_TARGET:    cfg_reg.eject_target    <= cfg_data;
                cpsc_pkg::CFG_TRANSFER_TARGET: cfg_reg.transfer_target <= cfg_data;
                cpsc_pkg::CFG_HOME_TARGET:     cfg_reg.home_target     <= cfg_data;
                cpsc_pkg::CFG_BACKLASH:
                    cfg_reg.backlash_offset <= cfg_data[cpsc_pkg::THR_W-1:0];
                cpsc_pkg::CFG_STALL_THRESHOLD:
                    cfg_reg.stall_threshold <= cfg_data[cpsc_pkg::THR_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // front half: accept and classify
    cpsc_front u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .encoder_position (encoder_position),
        .cfg              (cfg_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (push_data)
    );

    // decoupling FIFO
    cpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_data)
    );

    // back half: state update and result
    cpsc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_data          (pop_data),
        .q_pop           (q_pop),
        .stall_threshold (cfg_reg.stall_threshold),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .res             (res)
    );

    assign mode               = res.mode;
    assign drive              = res.drive;
    assign duty               = res.duty;
    assign compare_position   = res.compare_position;
    assign compare_less_equal = res.compare_less_equal;
    assign lamp_on            = res.lamp_on;
    assign stall_flag         = res.stall_flag;
    assign clear_position     = res.clear_position;

endmodule
`default_nettype wire
